[rtl/sha_pkg.sv]
// ----------------------------------------------------------------------------
// sha_pkg
// Types, round constants and round functions for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_LOADW,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } t_state;

    typedef logic [31:0] t_word;

    localparam t_word INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic t_word ror(input t_word x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word big_s0(input t_word x);
        return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic t_word big_s1(input t_word x);
        return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

    function automatic t_word sml_s0(input t_word x);
        return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word sml_s1(input t_word x);
        return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

endpackage

[rtl/sha_round.sv]
// ----------------------------------------------------------------------------
// sha_round
// Working variables a..h and one compression round per enabled cycle.
// ----------------------------------------------------------------------------
module sha_round (
    input  logic              i_clk,
    input  logic              i_load,
    input  sha_pkg::t_word    i_hash [8],
    input  logic              i_step,
    input  sha_pkg::t_word    i_w,
    input  logic [5:0]        i_round,
    output sha_pkg::t_word    o_v [8]
);
    import sha_pkg::*;

    t_word r_v [8];
    t_word t1;
    t_word t2;

    always_comb begin
        t1 = r_v[7] + big_s1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + ROUND_K[i_round] + i_w;
        t2 = big_s0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_v <= i_hash;
        end else if (i_step) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    assign o_v = r_v;

endmodule

[rtl/sha256_byte_stream_hasher.sv]
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 of a byte stream; digest given as eight 32-bit words.
// ----------------------------------------------------------------------------
// Input channel: one byte per word (i_message_byte, i_byte_present,
// i_end_of_message) with i_valid / o_stall. A word with neither a byte nor
// an end mark is taken and ignored. Words are taken one per cycle while idle.
// Bytes go to a 64x8 block memory. The 64th byte of a block starts a
// compression: the bytes are unpacked into a 16-word schedule memory,
// then 64 rounds run (each a schedule read, then a round step), then a
// hash update; stall stays high for the whole compression of a block.
// An end word pads (0x80, zeros, 64-bit length) through the same memory
// and runs one or two compressions: two when the length needs a second
// block or when the end word's byte completes a block.
// Digest words leave on o_valid / i_stall, word 0 first, o_digest_last on
// word 7. A stalled output holds its word; no input is taken until all eight
// leave. Synchronous active-low reset restores the initial hash and empties
// the buffer and bit count.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_message_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_digest_last
);
    import sha_pkg::*;

    t_state r_state, n_state;

    logic [7:0]  mem_buf [64];
    logic [7:0]  r_buf_rd;
    t_word       mem_w [16];
    t_word       r_w15, r_w2, r_w7, r_w16;

    t_word       r_h [8];
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic        r_final;
    logic        r_two;
    logic        r_padded;
    logic [6:0]  r_cnt;
    logic [2:0]  r_oidx;
    logic        r_rdy;

    logic        acc;
    logic        buf_we;
    logic [5:0]  buf_wa;
    logic [7:0]  buf_wd;
    logic [5:0]  buf_ra;
    logic [3:0]  rd_idx;
    t_word       v [8];
    t_word       w_cur;
    logic        rnd_load, rnd_step;
    logic [63:0] total;
    logic [7:0]  pad_d;
    t_word       r_pack;

    assign acc     = i_valid && !o_stall;
    assign o_stall = (r_state != ST_IDLE);
    assign total   = r_bits + {55'd0, r_fill, 3'd0};

    // padding byte for position r_cnt[5:0]
    always_comb begin
        if (r_cnt[5:0] >= 6'd56 && !(r_fill >= 6'd56 && !r_two)) begin
            pad_d = total[{~r_cnt[2:0], 3'b000} +: 8];
        end else if (r_cnt[5:0] == r_fill && !r_two) begin
            pad_d = PAD_BYTE;
        end else begin
            pad_d = 8'd0;
        end
    end

    always_comb begin
        buf_we = 1'b0;
        buf_wa = r_fill;
        buf_wd = i_message_byte;
        if (r_state == ST_IDLE && acc && i_byte_present) begin
            buf_we = 1'b1;
        end else if (r_state == ST_PAD) begin
            // first pass writes only from fill up; second block rewrites all
            buf_we = r_two ? 1'b1 : (r_cnt[5:0] >= r_fill);
            buf_wa = r_cnt[5:0];
            buf_wd = pad_d;
        end
        // one byte ahead of the unpack count
        buf_ra = (r_state == ST_LOADW) ? r_cnt[5:0] + 6'd1 : 6'd0;
    end

    always_ff @(posedge i_clk) begin
        if (buf_we) begin
            mem_buf[buf_wa] <= buf_wd;
        end
        r_buf_rd <= mem_buf[buf_ra];
    end

    // schedule memory: load writes packed words, rounds write new words
    always_comb begin
        w_cur = (r_cnt[5:0] < 6'd16) ? r_w16
                : r_w16 + sml_s0(r_w15) + r_w7 + sml_s1(r_w2);
    end

    assign rd_idx = r_cnt[3:0];

    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOADW) begin
            mem_w[r_cnt[5:2]] <= {r_pack[23:0], r_buf_rd};
        end else if (r_state == ST_ROUND && rnd_step) begin
            mem_w[r_cnt[3:0]] <= w_cur;
        end
        r_w16 <= mem_w[rd_idx];
        r_w15 <= mem_w[rd_idx + 4'd1];
        r_w7  <= mem_w[rd_idx + 4'd9];
        r_w2  <= mem_w[rd_idx + 4'd14];
    end

    // round r first reads the schedule, then steps
    assign rnd_load = (r_state == ST_LOADW && r_cnt == 7'd63);
    assign rnd_step = (r_state == ST_ROUND) && r_rdy;

    sha_round u_round (
        .i_clk   (i_clk),
        .i_load  (rnd_load),
        .i_hash  (r_h),
        .i_step  (rnd_step),
        .i_w     (w_cur),
        .i_round (r_cnt[5:0]),
        .o_v     (v)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (acc && i_byte_present && r_fill == 6'd63) begin
                    n_state = ST_LOAD;
                end else if (acc && i_end_of_message) begin
                    n_state = ST_PAD;
                end
            end
            ST_PAD:   n_state = (r_cnt[5:0] == 6'd63) ? ST_LOAD : ST_PAD;
            ST_LOAD:  n_state = ST_LOADW;
            ST_LOADW: n_state = (r_cnt == 7'd63) ? ST_ROUND : ST_LOADW;
            ST_ROUND: n_state = (rnd_step && r_cnt == 7'd63) ? ST_ADD : ST_ROUND;
            ST_ADD: begin
                if (!r_final) begin
                    n_state = ST_IDLE;
                end else if (!r_padded) begin
                    n_state = ST_PAD;
                end else if (!r_two && r_fill >= 6'd56) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT:  n_state = (!i_stall && r_oidx == 3'd7) ? ST_IDLE : ST_EMIT;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // set once padding has started for the current message
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || r_state == ST_IDLE) begin
            r_padded <= 1'b0;
        end else if (r_state == ST_PAD) begin
            r_padded <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h     <= INIT_H;
            r_fill  <= 6'd0;
            r_bits  <= 64'd0;
            r_final <= 1'b0;
            r_two   <= 1'b0;
            r_cnt   <= 7'd0;
            r_oidx  <= 3'd0;
            r_rdy   <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    r_cnt <= 7'd0;
                    if (acc && i_byte_present) begin
                        r_fill <= r_fill + 6'd1;
                        if (r_fill == 6'd63) begin
                            r_bits <= r_bits + 64'd512;
                            r_final <= i_end_of_message;
                            r_two <= 1'b0;
                        end else if (i_end_of_message) begin
                            r_final <= 1'b1;
                            r_two <= 1'b0;
                        end
                    end else if (acc && i_end_of_message) begin
                        r_final <= 1'b1;
                        r_two <= 1'b0;
                    end
                end
                ST_PAD: begin
                    r_cnt <= (r_cnt[5:0] == 6'd63) ? 7'd0 : r_cnt + 7'd1;
                end
                ST_LOAD: begin
                    r_cnt <= 7'd0;
                end
                ST_LOADW: begin
                    r_pack <= {r_pack[23:0], r_buf_rd};
                    if (r_cnt == 7'd63) begin
                        r_cnt <= 7'd0;
                        r_rdy <= 1'b0;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                ST_ROUND: begin
                    r_rdy <= !r_rdy;
                    if (rnd_step) begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                ST_ADD: begin
                    for (int k = 0; k < 8; k++) begin
                        r_h[k] <= r_h[k] + v[k];
                    end
                    r_cnt <= 7'd0;
                    if (r_final && r_padded && !r_two && r_fill >= 6'd56) begin
                        r_two <= 1'b1;
                    end else begin
                        r_two <= 1'b0;
                    end
                end
                ST_EMIT: begin
                    if (!i_stall) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            r_h     <= INIT_H;
                            r_fill  <= 6'd0;
                            r_bits  <= 64'd0;
                            r_final <= 1'b0;
                        end
                    end
                end
                default: r_cnt <= 7'd0;
            endcase
        end
    end

    assign o_valid       = (r_state == ST_EMIT);
    assign o_digest_word = r_h[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_digest_last = (r_oidx == 3'd7);

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_stall) else $error("input taken while busy");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_digest_last) |-> (o_word_index == 3'd7)) else $error("bad last");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(o_valid) && $past(i_stall) && o_valid) |-> $stable(o_word_index))
        else $error("index moved under stall");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Byte-stream SHA-256 hasher check: messages of random and edge lengths are
// fed with random idling on both sides; a behavioral SHA-256 predicts the
// eight digest words of each message, compared word by word on output.
// ----------------------------------------------------------------------------
module testbench;

    import sha_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       eom;
    } t_in_word;

    typedef struct packed {
        logic [31:0] digest;
        logic [2:0]  idx;
        logic        last;
    } t_out_word;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    localparam logic [31:0] KR [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam int CYCLE_LIMIT = 1000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_message_byte;
    logic        i_byte_present;
    logic        i_end_of_message;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_digest_last;

    sha256_byte_stream_hasher DUT (.*);

    // Predictor state
    logic [31:0] hash_state [8];
    logic [7:0]  blk [64];
    int          fill;
    logic [63:0] bit_total;

    t_in_word    pending_words [$];
    t_out_word   expected_digest [$];
    int          mismatch_count;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off_left;

    function automatic logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] wr, t1, t2, s0, s1;
        for (int k = 0; k < 16; k++)
            w[k] = {blk[4*k], blk[4*k+1], blk[4*k+2], blk[4*k+3]};
        for (int k = 0; k < 8; k++) v[k] = hash_state[k];
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                wr = w[r];
            end else begin
                s0 = rotr(w[(r-15)&15], 7) ^ rotr(w[(r-15)&15], 18) ^ (w[(r-15)&15] >> 3);
                s1 = rotr(w[(r-2)&15], 17) ^ rotr(w[(r-2)&15], 19) ^ (w[(r-2)&15] >> 10);
                wr = w[r&15] + s0 + w[(r-7)&15] + s1;
                w[r&15] = wr;
            end
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KR[r] + wr;
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int k = 0; k < 8; k++) hash_state[k] += v[k];
    endtask

    task automatic predict_digest(t_in_word iw);
        logic [63:0] total;
        t_out_word   ow;
        if (iw.present) begin
            blk[fill] = iw.data;
            fill++;
            if (fill == 64) begin
                compress();
                bit_total += 512;
                fill = 0;
            end
        end
        if (iw.eom) begin
            total = bit_total + 64'(fill) * 8;
            blk[fill] = 8'h80;
            for (int i = fill + 1; i < 64; i++) blk[i] = 8'h00;
            if (fill >= 56) begin
                compress();
                for (int i = 0; i < 56; i++) blk[i] = 8'h00;
            end
            for (int i = 0; i < 8; i++) blk[63-i] = total[8*i +: 8];
            compress();
            for (int i = 0; i < 8; i++) begin
                ow.digest = hash_state[i];
                ow.idx    = 3'(i);
                ow.last   = (i == 7);
                expected_digest.push_back(ow);
            end
            for (int k = 0; k < 8; k++) hash_state[k] = IV[k];
            fill = 0;
            bit_total = '0;
        end
    endtask

    task automatic queue_message(int len, bit noise);
        t_in_word iw;
        for (int i = 0; i < len; i++) begin
            iw.data = 8'($urandom);
            iw.present = 1'b1;
            iw.eom = (i == len - 1) && ($urandom_range(0, 1) == 1);
            pending_words.push_back(iw);
            if (noise && $urandom_range(0, 9) == 0)
                pending_words.push_back('{8'($urandom), 1'b0, 1'b0});
            if (iw.eom) return;
        end
        pending_words.push_back('{8'($urandom), 1'b0, 1'b1});
    endtask

    task automatic drain();
        while (expected_digest.size() != 0 || pending_words.size() != 0 || i_valid)
            @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    always begin
        i_clk = 1'b0; #10;
        i_clk = 1'b1; #10;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sha256_byte_stream_hasher test failed");
            $finish;
        end
    end

    // Driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || !o_stall) begin
                if (i_valid) predict_digest({i_message_byte, i_byte_present, i_end_of_message});
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    t_in_word iw;
                    iw = pending_words.pop_front();
                    i_valid <= 1'b1;
                    i_message_byte <= iw.data;
                    i_byte_present <= iw.present;
                    i_end_of_message <= iw.eom;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall
    always @(posedge i_clk) begin
        if (hold_off_left > 0) begin
            hold_off_left <= hold_off_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            t_out_word got, exp_w;
            got = {o_digest_word, o_word_index, o_digest_last};
            if (expected_digest.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < 10)
                    $display("unexpected digest word %h idx %0d", o_digest_word, o_word_index);
            end else begin
                exp_w = expected_digest.pop_front();
                if (got !== exp_w) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("digest mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                            exp_w.digest, exp_w.idx, exp_w.last,
                            o_digest_word, o_word_index, o_digest_last);
                end
            end
        end
    end

    initial begin
        for (int k = 0; k < 8; k++) hash_state[k] = IV[k];
        fill = 0;
        bit_total = '0;
        mismatch_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_left = 0;
        i_valid = 1'b0;
        i_message_byte = '0;
        i_byte_present = 1'b0;
        i_end_of_message = 1'b0;
        i_stall = 1'b0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty message, idle noise, byte+end, 0x00/0xff bytes,
        // and lengths around the one/two padding block boundary.
        pending_words.push_back('{8'hff, 1'b0, 1'b1});
        pending_words.push_back('{8'h55, 1'b0, 1'b0});
        pending_words.push_back('{8'hff, 1'b1, 1'b0});
        pending_words.push_back('{8'h00, 1'b1, 1'b1});
        pending_words.push_back('{8'hab, 1'b1, 1'b0});
        pending_words.push_back('{8'h00, 1'b0, 1'b1});
        drain();
        for (int len = 55; len <= 56; len++) begin
            for (int i = 0; i < len; i++)
                pending_words.push_back('{8'($urandom), 1'b1, 1'b0});
            pending_words.push_back('{8'h00, 1'b0, 1'b1});
        end
        for (int i = 0; i < 64; i++)
            pending_words.push_back('{8'($urandom), 1'b1, i == 63});
        drain();

        // Random, phased idling
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 52 : 14) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 52 : 14) : 0;
            for (int m = 0; m < 3; m++)
                queue_message(($urandom_range(0, 7) == 0) ? $urandom_range(50, 70)
                                                          : $urandom_range(0, 12), 1'b1);
            if (ph == 0) hold_off_left = 600;
            drain();
        end

        if (mismatch_count == 0 && expected_digest.size() == 0) begin
            $display("sha256_byte_stream_hasher test passed");
        end else begin
            $display("sha256_byte_stream_hasher test failed");
        end
        $finish;
    end

endmodule
